// ===== hdl/integer_to_ascii_formatter_defines.svh =====
// Assertion macros for the integer to ASCII formatter.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition must hold at every edge outside reset.
`define ITOA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("itoa: invariant violated");
// Consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoa: sequence violated");
`else
`define ITOA_ASSERT_ALWAYS(lbl, cond)
`define ITOA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/itoa_pkg.sv =====
// Shared types, constants and helpers of the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
package itoa_pkg;

  // Output length cap and derived counter width
  localparam int MAX_CHARS = 64;
  localparam int WIDTH_W   = 7;
  localparam int CAP_W     = $clog2(MAX_CHARS + 1);
  localparam int CNT_W     = (CAP_W > WIDTH_W) ? CAP_W : WIDTH_W;

  // Binary to BCD conversion
  localparam int VALUE_W    = 32;
  localparam int BCD_DIGITS = 10;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int NDIG_W     = $clog2(VALUE_W + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Conversion kinds
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_BIN  = 3'd2;
  localparam logic [2:0] KIND_OCT  = 3'd3;
  localparam logic [2:0] KIND_HEXL = 3'd4;
  localparam logic [2:0] KIND_HEXU = 3'd5;

  // Flag bits
  localparam int FLAG_PLUS   = 0;
  localparam int FLAG_SPACE  = 1;
  localparam int FLAG_PREFIX = 2;
  localparam int FLAG_PAD    = 3;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_BIN,
    RX_OCT,
    RX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_HEAD,
    ST_PAD,
    ST_DIGIT
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         kind;
    logic [6:0]         field_width;
    logic [3:0]         format_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    radix_t             radix;
    logic               upper;
    logic [7:0]         head0;
    logic [7:0]         head1;
    logic [1:0]         nhead;
    logic               pad_en;
    logic [6:0]         width;
  } desc_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CH_UP_A + {4'd0, d} - 8'd10;
    end else begin
      ch = CH_LOW_A + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// ===== hdl/itoa_front.sv =====
// Front end: accepts requests and classifies them into sign/prefix, radix and magnitude.
// Depends on itoa_pkg; feeds itoa_queue.
module itoa_front
  import itoa_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output desc_t    push_data,
  input  logic     q_full
);

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the request
  always_comb begin
    push_data        = '0;
    push_data.mag    = $unsigned(in_data.value);
    push_data.radix  = RX_DEC;
    push_data.upper  = 1'b0;
    push_data.head0  = CH_ZERO;
    push_data.head1  = CH_ZERO;
    push_data.nhead  = 2'd0;
    push_data.pad_en = in_data.format_flags[FLAG_PAD];
    push_data.width  = in_data.field_width;
    unique case (in_data.kind)
      KIND_SDEC: begin
        if (in_data.value[31]) begin
          push_data.head0 = CH_MINUS;
          push_data.nhead = 2'd1;
          push_data.mag   = 32'd0 - $unsigned(in_data.value);
        end else if (in_data.format_flags[FLAG_PLUS]) begin
          push_data.head0 = CH_PLUS;
          push_data.nhead = 2'd1;
        end else if (in_data.format_flags[FLAG_SPACE]) begin
          push_data.head0 = CH_SPACE;
          push_data.nhead = 2'd1;
        end
      end
      KIND_BIN: begin
        push_data.radix = RX_BIN;
      end
      KIND_OCT: begin
        push_data.radix = RX_OCT;
        if (in_data.format_flags[FLAG_PREFIX]) begin
          push_data.nhead = 2'd1;
        end
      end
      KIND_HEXL, KIND_HEXU: begin
        push_data.radix = RX_HEX;
        push_data.upper = (in_data.kind == KIND_HEXU);
        push_data.head1 = (in_data.kind == KIND_HEXU) ? CH_UP_X : CH_LOW_X;
        if (in_data.format_flags[FLAG_PREFIX]) begin
          push_data.nhead = 2'd2;
        end
      end
      default: begin
        // unsigned decimal and unused kinds
        push_data.radix = RX_DEC;
      end
    endcase
  end

endmodule

// ===== hdl/itoa_queue.sv =====
// Short request queue between the front end and the back end.
// Depends on itoa_pkg for the descriptor type and depth.
module itoa_queue
  import itoa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t pop_data,
  output logic  empty
);

  desc_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/itoa_back.sv =====
// Back end: converts the magnitude to digits and emits the characters one per cycle unless out_stall holds them.
// Depends on itoa_pkg; takes requests from itoa_queue.
module itoa_back
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  desc_t     q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  back_state_t state_r, state_nxt;

  desc_t                      desc_r;
  logic [VALUE_W-1:0]         shift_r;
  logic [BCD_DIGITS-1:0][3:0] bcd_r, bcd_adj, bcd_nxt;
  logic [NDIG_W-1:0]          bitsig_r, bitsig_nxt;
  logic [STEP_W-1:0]          step_r;
  logic [NDIG_W-1:0]          ndig_r, ndig_c;
  logic [CNT_W-1:0]           npad_r, npad_c;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic                       can_emit;
  logic                       emit;
  logic                       last_c;
  logic [7:0]                 char_c;
  logic [3:0]                 digit_c;
  logic                       bit_in;
  logic [BCD_DIGITS*4:0]      bcd_wide;
  logic [12:0]                oct_prod;
  logic [NDIG_W:0]            hex_sum;
  logic [CNT_W-1:0]           nat_c, total_c;
  logic [10:0][2:0]           oct_v;
  logic [7:0][3:0]            hex_v;

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shift-and-add-3 step of the binary to BCD conversion
  always_comb begin
    bit_in = shift_r[VALUE_W-1];
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_wide    = {bcd_adj, bit_in};
    bcd_nxt     = bcd_wide[BCD_DIGITS*4-1:0];
    bitsig_nxt  = (bitsig_r != '0 || bit_in) ? bitsig_r + 1'b1 : bitsig_r;
  end

  // Count digits and pad zeros once conversion is done
  always_comb begin
    oct_prod = (13'(bitsig_r) + 13'd2) * 13'd43;
    hex_sum  = (NDIG_W + 1)'(bitsig_r) + (NDIG_W + 1)'(3);
    ndig_c   = NDIG_W'(1);
    unique case (desc_r.radix)
      RX_DEC: begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
          if (bcd_r[i] != 4'd0) begin
            ndig_c = NDIG_W'(i + 1);
          end
        end
      end
      RX_BIN: begin
        if (bitsig_r != '0) ndig_c = bitsig_r;
      end
      RX_OCT: begin
        if (bitsig_r != '0) ndig_c = NDIG_W'(oct_prod[12:7]);
      end
      RX_HEX: begin
        if (bitsig_r != '0) ndig_c = NDIG_W'(hex_sum[NDIG_W:2]);
      end
    endcase
    nat_c   = CNT_W'(desc_r.nhead) + CNT_W'(ndig_c);
    total_c = nat_c;
    if (desc_r.pad_en && CNT_W'(desc_r.width) > nat_c) begin
      total_c = CNT_W'(desc_r.width);
    end
    if (total_c > CNT_W'(MAX_CHARS)) begin
      total_c = CNT_W'(MAX_CHARS);
    end
    npad_c = total_c - nat_c;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (step_r == STEP_W'(VALUE_W - 1)) state_nxt = ST_SIZE;
      end
      ST_SIZE: begin
        if (desc_r.nhead != 2'd0) begin
          state_nxt = ST_HEAD;
        end else if (npad_c != '0) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_HEAD: begin
        if (can_emit && idx_r == CNT_W'(desc_r.nhead) - 1'b1) begin
          state_nxt = (npad_r != '0) ? ST_PAD : ST_DIGIT;
        end
      end
      ST_PAD: begin
        if (can_emit && idx_r == npad_r - 1'b1) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (can_emit && idx_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: pop, emit and the character
  always_comb begin
    oct_v   = {1'b0, desc_r.mag};
    hex_v   = desc_r.mag;
    pop     = (state_r == ST_IDLE) && !q_empty;
    emit    = 1'b0;
    last_c  = 1'b0;
    char_c  = CH_ZERO;
    digit_c = 4'd0;
    unique case (desc_r.radix)
      RX_DEC: digit_c = bcd_r[idx_r[3:0]];
      RX_BIN: digit_c = {3'd0, desc_r.mag[idx_r[4:0]]};
      RX_OCT: digit_c = {1'b0, oct_v[idx_r[3:0]]};
      RX_HEX: digit_c = hex_v[idx_r[2:0]];
    endcase
    unique case (state_r)
      ST_HEAD: begin
        emit   = can_emit;
        char_c = (idx_r == '0) ? desc_r.head0 : desc_r.head1;
      end
      ST_PAD: begin
        emit   = can_emit;
        char_c = CH_ZERO;
      end
      ST_DIGIT: begin
        emit   = can_emit;
        char_c = digit_char(digit_c, desc_r.upper);
        last_c = (idx_r == '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Index into the current phase: restart on phase change
  always_comb begin
    idx_nxt = idx_r;
    if (state_nxt != state_r) begin
      unique case (state_nxt)
        ST_DIGIT: idx_nxt = (state_r == ST_SIZE) ? CNT_W'(ndig_c) - 1'b1
                                                 : CNT_W'(ndig_r) - 1'b1;
        default:  idx_nxt = '0;
      endcase
    end else if (emit) begin
      idx_nxt = (state_r == ST_DIGIT) ? idx_r - 1'b1 : idx_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (pop) begin
      desc_r   <= q_data;
      shift_r  <= q_data.mag;
      bcd_r    <= '0;
      bitsig_r <= '0;
      step_r   <= '0;
    end else if (state_r == ST_CONV) begin
      shift_r  <= {shift_r[VALUE_W-2:0], 1'b0};
      bcd_r    <= bcd_nxt;
      bitsig_r <= bitsig_nxt;
      step_r   <= step_r + 1'b1;
    end
    if (state_r == ST_SIZE) begin
      ndig_r <= ndig_c;
      npad_r <= npad_c;
    end
    if (emit) begin
      out_data_r.character <= char_c;
      out_data_r.last_char <= last_c;
    end
  end

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_stall
// out_      output     out_item_t  out_valid / out_stall
//
// A number of N characters (1 to 64) is picked up by the back end, put
// through 32 steps of the shift-and-add-3 BCD loop and its field sized;
// then one character per cycle goes out unless out_stall holds it. The
// front end classifies and queues up to two further requests meanwhile.
// Synchronous active-low reset empties the queue and the output register.
// Top level of the integer to ASCII formatter; depends on itoa_pkg,
// itoa_front, itoa_queue, itoa_back and the assertion macro header.
`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic  push;
  desc_t push_data;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  desc_t pop_data;

  // Accept and classify
  itoa_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Decouple front and back
  itoa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Convert and emit
  itoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Pop only a filled queue
  `ITOA_ASSERT_ALWAYS(a_pop_nonempty, !pop || !q_empty)
  // An accepted request is queued in the next cycle
  `ITOA_ASSERT_NEXT(a_push_lands, in_valid && !in_stall, !q_empty)
  // After the final character is taken, no character follows at once
  `ITOA_ASSERT_NEXT(a_gap_after_last, out_valid && !out_stall && out_data.last_char, !out_valid)

endmodule
